// ----- rtl/weighted_prime_race_tracker_assert.svh -----
// Assertion macros shared by the prime race tracker RTL.
// Included by weighted_prime_race_tracker.sv and wprt_mul.sv; no other dependencies.
`ifndef WEIGHTED_PRIME_RACE_TRACKER_ASSERT_SVH
`define WEIGHTED_PRIME_RACE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define WPRT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset
`define WPRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WPRT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define WPRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/wprt_pkg.sv -----
// Package for the prime race tracker: defaults, codes, state types and helpers.
// Used by wprt_mul.sv and weighted_prime_race_tracker.sv; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wprt_pkg;

  // Parameter defaults
  localparam int NumPowersDef = 4;
  localparam int PrimeBitsDef = 32;

  // Fixed widths
  localparam int DiffW = 128;
  localparam int SpanW = 32;
  localparam int LimbW = 32;

  // A prime whose residue mod 4 is this value adds to the races
  localparam logic [1:0] ResidueThree = 2'd3;
  // Reset value of the last event point
  localparam logic [7:0] FirstPoint = 8'd3;

  typedef enum logic [1:0] {
    LEAD_NONE  = 2'd0,
    LEAD_THREE = 2'd1,
    LEAD_ONE   = 2'd2
  } lead_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_ADD,
    ST_LEAD,
    ST_MUL_WAIT,
    ST_EMIT,
    ST_HOLD
  } state_e;

  // Sequencer to multiplier
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  // Multiplier to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Saturating 32-bit add
  function automatic logic [SpanW-1:0] sat_add(input logic [SpanW-1:0] a,
                                              input logic [SpanW-1:0] b);
    logic [SpanW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SpanW] ? {SpanW{1'b1}} : s[SpanW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wprt_mul.sv -----
// Shared multiplier: 128-bit operand times a prime, modulo 2^128, one 32-bit limb a pass.
// Depends on wprt_pkg and weighted_prime_race_tracker_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_prime_race_tracker_assert.svh"

module wprt_mul #(
  parameter int PRIME_BITS = wprt_pkg::PrimeBitsDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wprt_pkg::mul_ctrl_t                ctrl_i,
  input  wire  [wprt_pkg::DiffW-1:0]         a_i,
  input  wire  [PRIME_BITS-1:0]              b_i,
  output wprt_pkg::mul_stat_t                stat_o,
  output logic [wprt_pkg::DiffW-1:0]         result_o
);

  localparam int ProdW  = wprt_pkg::LimbW + PRIME_BITS;
  localparam int NumLimbs = wprt_pkg::DiffW / wprt_pkg::LimbW;
  localparam logic [2:0] LastStep = 3'(NumLimbs);

  logic                        active_q;
  logic                        done_q;
  logic [2:0]                  step_q;
  logic [ProdW-1:0]            prod_q;
  logic [wprt_pkg::DiffW-1:0]  acc_q;
  logic [1:0]                  shift_idx;
  logic [wprt_pkg::DiffW-1:0]  add_term;
  logic [wprt_pkg::LimbW-1:0]  limb;

  // Pick the limb for this pass and align the previous partial product
  always_comb begin
    limb      = a_i[{step_q[1:0], 5'd0} +: wprt_pkg::LimbW];
    shift_idx = 2'(step_q - 3'd1);
    add_term  = wprt_pkg::DiffW'(prod_q) << {shift_idx, 5'd0};
  end

  // Sequence the passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (active_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == LastStep) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Multiply one limb, accumulate the product of the pass before
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (active_q) begin
      if (step_q != LastStep) begin
        prod_q <= ProdW'(limb) * ProdW'(b_i);
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + add_term;
      end
    end
  end

  assign stat_o.busy = active_q;
  assign stat_o.done = done_q;
  assign result_o    = acc_q;

  `WPRT_ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, done_q, !active_q)
  `WPRT_ASSERT_NEXT(a_last_pass_done, clk_i, rst_ni,
                    active_q && (step_q == LastStep) && !ctrl_i.start, done_q)

endmodule

`default_nettype wire

// ----- rtl/weighted_prime_race_tracker.sv -----
// Top level of the prime race tracker: sequencer, race state and result register.
// Depends on wprt_pkg, wprt_mul and weighted_prime_race_tracker_assert.svh.
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------------------
//  input   | in_valid_i / in_stall_o  | req_type_i, value_i
//  output  | out_valid_o / out_stall_i| race_index_o, difference_*_o, spans, last_of_run_o
//
// One item at a time; in_stall_o is high from the transfer until the item is done.
// Prime event: the races are updated in turn; between races the sequencer waits on the
// shared 32-bit multiplier, which builds each next power in four limb passes.
// Finish: ST_GAP, then ST_EMIT and ST_HOLD for each result, leaving ST_HOLD only while
// out_stall_i is low; a stall holds the result register and the sequencer.
// Reset clears all race state; the last event point resets to 3.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_prime_race_tracker_assert.svh"

module weighted_prime_race_tracker #(
  parameter int NUM_POWERS = wprt_pkg::NumPowersDef,
  parameter int PRIME_BITS = wprt_pkg::PrimeBitsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                req_type_i,
  input  wire  [31:0]        value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [1:0]         race_index_o,
  output logic signed [63:0] difference_high_o,
  output logic [63:0]        difference_low_o,
  output logic [31:0]        first_one_side_prime_o,
  output logic [31:0]        lead_changes_o,
  output logic [31:0]        three_side_span_o,
  output logic [31:0]        total_span_o,
  output logic               last_of_run_o
);

  localparam int IdxW  = (NUM_POWERS > 1) ? $clog2(NUM_POWERS) : 1;
  localparam int DiffW = wprt_pkg::DiffW;
  localparam int SpanW = wprt_pkg::SpanW;
  localparam logic [IdxW-1:0] LastRace = IdxW'(NUM_POWERS - 1);

  wprt_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]       race_q;
  logic                  finish_q;
  logic [PRIME_BITS-1:0] prime_q;
  logic [DiffW-1:0]      pw_q;
  logic [PRIME_BITS-1:0] last_pt_q;
  logic [SpanW-1:0]      tspan_q;

  logic [DiffW-1:0]      diff_q  [NUM_POWERS];
  wprt_pkg::lead_e       leader_q[NUM_POWERS];
  logic [SpanW-1:0]      chg_q   [NUM_POWERS];
  logic [PRIME_BITS-1:0] first_q [NUM_POWERS];
  logic [SpanW-1:0]      lspan_q [NUM_POWERS];

  logic                  out_valid_q;
  logic [1:0]            oidx_q;
  logic [DiffW-1:0]      odiff_q;
  logic [SpanW-1:0]      ofirst_q;
  logic [SpanW-1:0]      ochg_q;
  logic [SpanW-1:0]      olspan_q;
  logic [SpanW-1:0]      otspan_q;
  logic                  olast_q;

  wprt_pkg::mul_ctrl_t   mul_ctrl;
  wprt_pkg::mul_stat_t   mul_stat;
  logic [DiffW-1:0]      mul_result;

  logic                  in_xfer;
  logic                  race_last;
  logic [PRIME_BITS-1:0] gap_raw;
  logic [SpanW-1:0]      gap;
  logic                  plus;
  logic [DiffW-1:0]      diff_cur;
  logic [DiffW-1:0]      diff_new;
  wprt_pkg::lead_e       lead_new;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign race_last = (race_q == LastRace);

  // Gap, signed update and leader of the race in work
  always_comb begin
    gap_raw  = (prime_q > last_pt_q) ? (prime_q - last_pt_q) : '0;
    gap      = SpanW'(gap_raw);
    plus     = (prime_q[1:0] == wprt_pkg::ResidueThree);
    diff_cur = diff_q[race_q];
    diff_new = plus ? (diff_cur + pw_q) : (diff_cur - pw_q);
    if (diff_cur[DiffW-1]) begin
      lead_new = wprt_pkg::LEAD_ONE;
    end else if (|diff_cur) begin
      lead_new = wprt_pkg::LEAD_THREE;
    end else begin
      lead_new = wprt_pkg::LEAD_NONE;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d        = state_q;
    mul_ctrl.start = 1'b0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      wprt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = wprt_pkg::ST_GAP;
      end
      wprt_pkg::ST_GAP: begin
        state_d = finish_q ? wprt_pkg::ST_EMIT : wprt_pkg::ST_ADD;
      end
      wprt_pkg::ST_ADD: begin
        state_d = wprt_pkg::ST_LEAD;
      end
      wprt_pkg::ST_LEAD: begin
        if (race_last) begin
          state_d = wprt_pkg::ST_IDLE;
        end else begin
          mul_ctrl.start = 1'b1;
          state_d        = wprt_pkg::ST_MUL_WAIT;
        end
      end
      wprt_pkg::ST_MUL_WAIT: begin
        if (mul_stat.done) state_d = wprt_pkg::ST_ADD;
      end
      wprt_pkg::ST_EMIT: begin
        state_d = wprt_pkg::ST_HOLD;
      end
      wprt_pkg::ST_HOLD: begin
        if (!out_stall_i) state_d = race_last ? wprt_pkg::ST_IDLE : wprt_pkg::ST_EMIT;
      end
      default: state_d = wprt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= wprt_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Race state, spans and sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      race_q      <= '0;
      out_valid_q <= 1'b0;
      tspan_q     <= '0;
      last_pt_q   <= PRIME_BITS'(wprt_pkg::FirstPoint);
      for (int m = 0; m < NUM_POWERS; m++) begin
        diff_q[m]   <= '0;
        leader_q[m] <= wprt_pkg::LEAD_NONE;
        chg_q[m]    <= '0;
        first_q[m]  <= '0;
        lspan_q[m]  <= '0;
      end
    end else begin
      unique case (state_q)
        wprt_pkg::ST_GAP: begin
          // Charge the gap to the total and to every race the 3-side leads
          tspan_q   <= wprt_pkg::sat_add(tspan_q, gap);
          last_pt_q <= prime_q;
          race_q    <= '0;
          for (int m = 0; m < NUM_POWERS; m++) begin
            if (leader_q[m] == wprt_pkg::LEAD_THREE) begin
              lspan_q[m] <= wprt_pkg::sat_add(lspan_q[m], gap);
            end
          end
        end
        wprt_pkg::ST_ADD: begin
          diff_q[race_q] <= diff_new;
        end
        wprt_pkg::ST_LEAD: begin
          // Switch leader only on a nonzero sign that differs
          if (lead_new != wprt_pkg::LEAD_NONE && lead_new != leader_q[race_q]) begin
            if (leader_q[race_q] != wprt_pkg::LEAD_NONE) begin
              chg_q[race_q] <= chg_q[race_q] + 1'b1;
              if (lead_new == wprt_pkg::LEAD_ONE && first_q[race_q] == '0) begin
                first_q[race_q] <= prime_q;
              end
            end
            leader_q[race_q] <= lead_new;
          end
        end
        wprt_pkg::ST_MUL_WAIT: begin
          if (mul_stat.done) race_q <= race_q + 1'b1;
        end
        wprt_pkg::ST_EMIT: begin
          out_valid_q <= 1'b1;
        end
        wprt_pkg::ST_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (!race_last) race_q <= race_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture, running power and result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      finish_q <= req_type_i;
      prime_q  <= value_i[PRIME_BITS-1:0];
    end
    if (state_q == wprt_pkg::ST_GAP) begin
      pw_q <= DiffW'(1);
    end else if (state_q == wprt_pkg::ST_MUL_WAIT && mul_stat.done) begin
      pw_q <= mul_result;
    end
    if (state_q == wprt_pkg::ST_EMIT) begin
      oidx_q   <= 2'(race_q);
      odiff_q  <= diff_cur;
      ofirst_q <= SpanW'(first_q[race_q]);
      ochg_q   <= chg_q[race_q];
      olspan_q <= lspan_q[race_q];
      otspan_q <= tspan_q;
      olast_q  <= race_last;
    end
  end

  wprt_mul #(
    .PRIME_BITS(PRIME_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mul_ctrl),
    .a_i     (pw_q),
    .b_i     (prime_q),
    .stat_o  (mul_stat),
    .result_o(mul_result)
  );

  assign out_valid_o            = out_valid_q;
  assign race_index_o           = oidx_q;
  assign difference_high_o      = odiff_q[DiffW-1:DiffW/2];
  assign difference_low_o       = odiff_q[DiffW/2-1:0];
  assign first_one_side_prime_o = ofirst_q;
  assign lead_changes_o         = ochg_q;
  assign three_side_span_o      = olspan_q;
  assign total_span_o           = otspan_q;
  assign last_of_run_o          = olast_q;

  `WPRT_ASSERT_IMPLY(a_out_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o)
  `WPRT_ASSERT_IMPLY(a_last_is_top_race, clk_i, rst_ni,
                     out_valid_o && last_of_run_o, race_index_o == 2'(LastRace))
  `WPRT_ASSERT_IMPLY(a_start_unit_free, clk_i, rst_ni, mul_ctrl.start, !mul_stat.busy)
  `WPRT_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_o)

endmodule

`default_nettype wire
